// ===== rtl/core/ips_pkg.sv =====
// ---------------------------------------------------------------------------
// ips_pkg
// Types, codes and lamp patterns shared by the intersection phase sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package ips_pkg;

    // command codes of an input word
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_BTN_A = 2'd1;
    localparam logic [1:0] CMD_BTN_B = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_UNIT_TICKS     = 3'd0;
    localparam logic [2:0] CFG_TRAM_TIME      = 3'd1;
    localparam logic [2:0] CFG_BUS_TIME       = 3'd2;
    localparam logic [2:0] CFG_MAIN_GO_TIME   = 3'd3;
    localparam logic [2:0] CFG_MAIN_TURN_TIME = 3'd4;
    localparam logic [2:0] CFG_SIDE_TURN_TIME = 3'd5;
    localparam logic [2:0] CFG_WALK_TIME      = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // phase codes
    localparam logic [2:0] PH_NONE      = 3'd0;
    localparam logic [2:0] PH_TRAM      = 3'd1;
    localparam logic [2:0] PH_BUS       = 3'd2;
    localparam logic [2:0] PH_MAIN_GO   = 3'd3;
    localparam logic [2:0] PH_MAIN_TURN = 3'd4;
    localparam logic [2:0] PH_SIDE_TURN = 3'd5;
    localparam logic [2:0] PH_PED       = 3'd6;

    localparam int NUM_REQ = 6;

    localparam logic [20:0] ELAPSED_MAX = 21'h1FFFFF;

    // lamp patterns
    localparam logic [7:0] L_S_STOP       = 8'h32;
    localparam logic [7:0] L_N_STOP       = 8'h2A;
    localparam logic [7:0] L_SIDE_STOP    = 8'h80;
    localparam logic [7:0] L_S_LEAD       = 8'h52;
    localparam logic [7:0] L_N_LEAD       = 8'h4A;
    localparam logic [7:0] L_S_TRAM_GO    = 8'h31;
    localparam logic [7:0] L_N_TRAM_GO    = 8'h26;
    localparam logic [7:0] L_N_HOLD       = 8'h8A;
    localparam logic [7:0] L_N_BUS_GO     = 8'h9A;
    localparam logic [7:0] L_S_TURN_STOP  = 8'h92;
    localparam logic [7:0] L_S_TURN_AMBER = 8'h8A;
    localparam logic [7:0] L_S_TURN_GO    = 8'h86;
    localparam logic [7:0] L_SIDE_GO      = 8'h20;
    localparam logic [7:0] L_SIDE_AMBER   = 8'h40;
    localparam logic [7:0] L_N_PED_ON     = 8'h89;
    localparam logic [7:0] L_N_PED_OFF    = 8'h88;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] buttons;
    } ips_in_t;

    typedef struct packed {
        logic [7:0] lamps_south;
        logic [7:0] lamps_north;
        logic [7:0] lamps_side;
        logic [5:0] pending;
        logic [2:0] serving;
        logic       ticking;
    } ips_out_t;

    typedef struct packed {
        logic [11:0] unit_ticks;
        logic [7:0]  tram_time;
        logic [7:0]  bus_time;
        logic [7:0]  main_go_time;
        logic [7:0]  main_turn_time;
        logic [7:0]  side_turn_time;
        logic [7:0]  walk_time;
    } ips_cfg_t;

    typedef struct packed {
        logic [5:0]  mask;
        logic [2:0]  phase;
        logic [20:0] elapsed;
        logic        begun;
        logic [2:0]  amber;
        logic        green;
        logic        idle;
        logic        ticking;
        logic [7:0]  lamp0;
        logic [7:0]  lamp1;
        logic [7:0]  lamp2;
    } ips_state_t;

    localparam ips_state_t STATE_RESET = '{
        mask: 6'd0, phase: PH_NONE, elapsed: 21'd0, begun: 1'b0, amber: 3'd0,
        green: 1'b0, idle: 1'b0, ticking: 1'b1, lamp0: 8'd0, lamp1: 8'd0,
        lamp2: 8'd0
    };

    // request bit of a phase, none for no phase
    function automatic logic [5:0] phase_bit(input logic [2:0] phase);
        logic [5:0] bits;
        bits = 6'd0;
        if (phase != PH_NONE)
        begin
            bits = 6'd1 << (phase - 3'd1);
        end
        return bits;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ips_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// ips_cfg_regs
// Timing configuration registers with their reset values.
// ---------------------------------------------------------------------------
`default_nettype none

module ips_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [ips_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ips_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output ips_pkg::ips_cfg_t                     cfg
);

    ips_pkg::ips_cfg_t cfg_reg;
    ips_pkg::ips_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ips_pkg::CFG_UNIT_TICKS:     cfg_next.unit_ticks     = cfg_wdata;
                ips_pkg::CFG_TRAM_TIME:      cfg_next.tram_time      = cfg_wdata[7:0];
                ips_pkg::CFG_BUS_TIME:       cfg_next.bus_time       = cfg_wdata[7:0];
                ips_pkg::CFG_MAIN_GO_TIME:   cfg_next.main_go_time   = cfg_wdata[7:0];
                ips_pkg::CFG_MAIN_TURN_TIME: cfg_next.main_turn_time = cfg_wdata[7:0];
                ips_pkg::CFG_SIDE_TURN_TIME: cfg_next.side_turn_time = cfg_wdata[7:0];
                ips_pkg::CFG_WALK_TIME:      cfg_next.walk_time      = cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_ticks     <= 12'd300;
            cfg_reg.tram_time      <= 8'd10;
            cfg_reg.bus_time       <= 8'd4;
            cfg_reg.main_go_time   <= 8'd10;
            cfg_reg.main_turn_time <= 8'd5;
            cfg_reg.side_turn_time <= 8'd5;
            cfg_reg.walk_time      <= 8'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ips_step_logic.sv =====
// ---------------------------------------------------------------------------
// ips_step_logic
// Next phase state for one input word: button latching and tick sequencing.
// ---------------------------------------------------------------------------
`default_nettype none

module ips_step_logic (
    input  wire ips_pkg::ips_cfg_t   cfg,
    input  wire ips_pkg::ips_in_t    word,
    input  wire ips_pkg::ips_state_t cur,
    output ips_pkg::ips_state_t      nxt
);

    logic [2:0]  phase_sel;
    logic [2:0]  lowest;
    logic [7:0]  green_len;
    logic [19:0] tu;
    logic [14:0] ku;
    logic [21:0] u22;
    logic [21:0] u6;
    logic [21:0] u8;
    logic [21:0] u12;
    logic [21:0] tu2;
    logic [21:0] th_end;
    logic [21:0] th_amb;
    logic [21:0] th_k;
    logic [21:0] ev2;
    logic [20:0] e1;
    logic [20:0] ev;
    logic        hit_end;
    logic        hit_amb;
    logic        hit_k;
    logic        hit_c;
    logic [5:0]  mask_fin;
    logic        lead_next;
    logic [7:0]  b;

    always_comb
    begin
        lowest = ips_pkg::PH_NONE;
        for (int n = ips_pkg::NUM_REQ - 1; n >= 0; n--)
        begin
            if (cur.mask[n])
            begin
                lowest = 3'(n + 1);
            end
        end
    end

    assign phase_sel = (cur.phase == ips_pkg::PH_NONE && cur.mask != 6'd0) ? lowest : cur.phase;

    always_comb
    begin
        case (phase_sel)
            ips_pkg::PH_TRAM:      green_len = cfg.tram_time;
            ips_pkg::PH_BUS:       green_len = cfg.bus_time;
            ips_pkg::PH_MAIN_GO:   green_len = cfg.main_go_time;
            ips_pkg::PH_MAIN_TURN: green_len = cfg.main_turn_time;
            ips_pkg::PH_SIDE_TURN: green_len = cfg.side_turn_time;
            ips_pkg::PH_PED:       green_len = cfg.walk_time;
            default:               green_len = 8'd0;
        endcase
    end

    // thresholds in half-tick units: compare 2*elapsed against units*unit_ticks
    assign tu  = 20'(green_len) * 20'(cfg.unit_ticks);
    assign ku  = 15'(cur.amber) * 15'(cfg.unit_ticks);
    assign u22 = 22'(cfg.unit_ticks);
    assign u6  = (u22 << 2) + (u22 << 1);
    assign u8  = u22 << 3;
    assign u12 = (u22 << 3) + (u22 << 2);
    assign tu2 = {1'b0, tu, 1'b0};

    always_comb
    begin
        case (phase_sel)
            ips_pkg::PH_MAIN_GO:   th_end = tu2 + u6;
            ips_pkg::PH_MAIN_TURN: th_end = tu2 + u12;
            ips_pkg::PH_SIDE_TURN: th_end = tu2 + u12;
            default:               th_end = tu2 + u8;
        endcase
    end

    assign th_amb = tu2 + u6;
    assign th_k   = tu2 + 22'(ku);

    assign e1  = (cur.begun && cur.elapsed != ips_pkg::ELAPSED_MAX) ?
                 cur.elapsed + 21'd1 : cur.elapsed;
    assign ev  = cur.begun ? e1 : 21'd0;
    assign ev2 = {ev, 1'b0};

    assign hit_end = ev2 >= th_end;
    assign hit_amb = ev2 >= th_amb;
    assign hit_k   = ev2 >= th_k;
    assign hit_c   = ev2 >= u6;

    assign mask_fin  = cur.mask & ~ips_pkg::phase_bit(phase_sel);
    assign lead_next = phase_sel == ips_pkg::PH_TRAM || phase_sel == ips_pkg::PH_BUS ||
                       phase_sel == ips_pkg::PH_MAIN_GO;
    assign b = word.buttons;

    always_comb
    begin
        nxt = cur;
        case (word.cmd)
            ips_pkg::CMD_BTN_A:
            begin
                nxt.ticking = 1'b1;
                if (!b[0] || !b[4]) nxt.mask[2] = 1'b1;
                if (!b[1])          nxt.mask[3] = 1'b1;
                if (!b[2] || !b[5]) nxt.mask[0] = 1'b1;
                if (!b[3])          nxt.mask[1] = 1'b1;
                if (!b[6])          nxt.mask[4] = 1'b1;
                if (!b[7])          nxt.mask[5] = 1'b1;
            end
            ips_pkg::CMD_BTN_B:
            begin
                nxt.ticking = 1'b1;
                if (!b[0] || !b[1]) nxt.mask[5] = 1'b1;
            end
            ips_pkg::CMD_TICK:
            begin
                if (cur.ticking)
                begin
                    nxt.elapsed = e1;
                    nxt.phase   = phase_sel;
                    if (cur.mask == 6'd0)
                    begin
                        if (!cur.idle)
                        begin
                            nxt.lamp0 = ips_pkg::L_S_STOP;
                            nxt.lamp1 = ips_pkg::L_N_STOP;
                            nxt.lamp2 = ips_pkg::L_SIDE_STOP;
                            nxt.idle  = 1'b1;
                        end
                        else
                        begin
                            nxt.ticking = 1'b0;
                        end
                    end
                    else if (cur.idle)
                    begin
                        // lead-in before the next phase
                        if (!cur.begun)
                        begin
                            if (!cur.mask[0] && !cur.mask[1] && !cur.mask[2] && cur.lamp0[5])
                                nxt.lamp0 = ips_pkg::L_S_LEAD;
                            if (!cur.mask[0] && !cur.mask[2] && cur.lamp1[5])
                                nxt.lamp1 = ips_pkg::L_N_LEAD;
                        end
                        nxt.begun   = !hit_c;
                        nxt.elapsed = hit_c ? 21'd0 : ev;
                        nxt.idle    = 1'b0;
                    end
                    else
                    begin
                        nxt.begun   = 1'b1;
                        nxt.elapsed = ev;
                        if (hit_end)
                        begin
                            nxt.mask    = mask_fin;
                            nxt.begun   = 1'b0;
                            nxt.elapsed = 21'd0;
                            nxt.amber   = 3'd0;
                            nxt.green   = 1'b0;
                            nxt.phase   = ips_pkg::PH_NONE;
                            nxt.idle    = lead_next && mask_fin != 6'd0;
                        end
                        case (phase_sel)
                            ips_pkg::PH_TRAM:
                            begin
                                if (hit_end)
                                begin
                                end
                                else if (hit_amb && cur.amber == 3'd0)
                                begin
                                    nxt.amber = 3'd1;
                                    nxt.lamp0 = ips_pkg::L_S_STOP;
                                    nxt.lamp1 = ips_pkg::L_N_STOP;
                                end
                                else if (hit_c && !cur.green)
                                begin
                                    nxt.green = 1'b1;
                                    nxt.lamp0 = ips_pkg::L_S_TRAM_GO;
                                    nxt.lamp1 = ips_pkg::L_N_TRAM_GO;
                                end
                            end
                            ips_pkg::PH_BUS:
                            begin
                                if (hit_end)
                                begin
                                end
                                else if (hit_amb && cur.amber == 3'd0)
                                begin
                                    nxt.amber = 3'd1;
                                    nxt.lamp1 = ips_pkg::L_N_HOLD;
                                end
                                else if (hit_c && !cur.green)
                                begin
                                    nxt.green = 1'b1;
                                    nxt.lamp1 = ips_pkg::L_N_BUS_GO;
                                    if (cur.mask[0] || cur.mask[2])
                                        nxt.lamp0 = ips_pkg::L_S_STOP;
                                end
                            end
                            ips_pkg::PH_MAIN_GO:
                            begin
                                if (!hit_end && hit_c)
                                begin
                                    nxt.lamp0 = ips_pkg::L_S_STOP;
                                    nxt.lamp1 = ips_pkg::L_N_STOP;
                                end
                            end
                            ips_pkg::PH_MAIN_TURN:
                            begin
                                if (hit_end)
                                begin
                                    nxt.lamp0 = ips_pkg::L_S_TURN_STOP;
                                end
                                else if (hit_amb && cur.amber == 3'd0)
                                begin
                                    nxt.amber = 3'd1;
                                    nxt.lamp0 = ips_pkg::L_S_TURN_AMBER;
                                end
                                else if (hit_c && !cur.green)
                                begin
                                    nxt.green = 1'b1;
                                    nxt.lamp0 = ips_pkg::L_S_TURN_GO;
                                    nxt.lamp1 = ips_pkg::L_N_HOLD;
                                end
                            end
                            ips_pkg::PH_SIDE_TURN:
                            begin
                                if (hit_end)
                                begin
                                    nxt.lamp2 = ips_pkg::L_SIDE_STOP;
                                end
                                else if (hit_amb && cur.amber == 3'd0)
                                begin
                                    nxt.amber = 3'd1;
                                    nxt.lamp2 = ips_pkg::L_SIDE_AMBER;
                                end
                                else if (hit_c && !cur.green)
                                begin
                                    nxt.green = 1'b1;
                                    nxt.lamp0 = ips_pkg::L_S_TURN_STOP;
                                    nxt.lamp1 = ips_pkg::L_N_HOLD;
                                    nxt.lamp2 = ips_pkg::L_SIDE_GO;
                                end
                            end
                            ips_pkg::PH_PED:
                            begin
                                if (hit_end)
                                begin
                                    nxt.lamp0 = ips_pkg::L_S_STOP;
                                    nxt.lamp1 = ips_pkg::L_N_HOLD;
                                end
                                else if (cur.amber <= 3'd5 && hit_k)
                                begin
                                    // flashing walk signal, one half unit a step
                                    nxt.lamp1 = cur.amber[0] ? ips_pkg::L_N_PED_ON :
                                                               ips_pkg::L_N_PED_OFF;
                                    nxt.amber = cur.amber + 3'd1;
                                end
                                else if (hit_c && !cur.green)
                                begin
                                    nxt.green = 1'b1;
                                    nxt.lamp0 = ips_pkg::L_S_TURN_STOP;
                                    nxt.lamp1 = ips_pkg::L_N_PED_ON;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/intersection_phase_sequencer.sv =====
// ---------------------------------------------------------------------------
// intersection_phase_sequencer
// Path: an accepted input word is held in the input register, then the phase
// update is written into the output register, from which the result leaves.
// Throughput: one word per cycle while the result side does not stall; the
// figure is set by the combinational phase update (green time times unit_ticks,
// threshold compares). Reset: requests, phase and lamps cleared, ticking on,
// timing at defaults.
`default_nettype none

module intersection_phase_sequencer (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire ips_pkg::ips_in_t                 item_data,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output ips_pkg::ips_out_t                     result_data,
    input  wire logic                             cfg_we,
    input  wire logic [ips_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ips_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    ips_pkg::ips_cfg_t   cfg;
    ips_pkg::ips_state_t state_reg;
    ips_pkg::ips_state_t state_next;
    ips_pkg::ips_in_t    s1_data_reg;
    ips_pkg::ips_out_t   out_data_reg;
    ips_pkg::ips_out_t   out_data_next;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                s1_go;
    logic                item_take;
    logic                step;

    ips_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ips_step_logic u_step (
        .cfg  (cfg),
        .word (s1_data_reg),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    assign s1_go      = !out_valid_reg || !result_stall;
    assign item_stall = s1_valid_reg && !s1_go;
    assign item_take  = item_valid && !item_stall;
    assign step       = s1_valid_reg && s1_go;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_take)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (step)
        begin
            out_valid_next            = 1'b1;
            out_data_next.lamps_south = state_next.lamp0;
            out_data_next.lamps_north = state_next.lamp1;
            out_data_next.lamps_side  = state_next.lamp2;
            out_data_next.pending     = state_next.mask;
            out_data_next.serving     = state_next.phase;
            out_data_next.ticking     = state_next.ticking;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ips_pkg::STATE_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (step)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            s1_data_reg <= item_data;
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    a_phase_requested: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase != ips_pkg::PH_NONE) |->
        ((state_reg.mask & ips_pkg::phase_bit(state_reg.phase)) != 6'd0))
        else $error("served phase has no pending request");

    a_stopped_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.ticking |-> (state_reg.mask == 6'd0 && state_reg.phase == ips_pkg::PH_NONE))
        else $error("ticking stopped with requests pending");

    a_flash_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.amber != 3'd7)
        else $error("flash step out of range");

    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> result_valid)
        else $error("processed word produced no result");

endmodule

`default_nettype wire

// ===== tb/intersection_phase_sequencer_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// intersection_phase_sequencer_test
// Self-checking bench for the phase sequencer. Tick and button words go in
// over the valid/stall channel and a behavioural copy of the sequencer
// forecasts each result word, which is compared field by field. Timing
// registers are reloaded between runs, from zero lengths up to the largest,
// while both sides idle and stall in random bursts.
// ---------------------------------------------------------------------------

module intersection_phase_sequencer_test;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // request bits, lowest is served first
    localparam int RQ_TRAM      = 0;
    localparam int RQ_BUS       = 1;
    localparam int RQ_MAIN_GO   = 2;
    localparam int RQ_MAIN_TURN = 3;
    localparam int RQ_SIDE_TURN = 4;
    localparam int RQ_PED       = 5;

    localparam int STOP_NS = 2_000_000;

    logic                           clk;
    logic                           rst_n;
    logic                           item_valid;
    logic                           item_stall;
    ips_pkg::ips_in_t               item_data;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    ips_pkg::ips_out_t              result_data;
    logic                           cfg_we;
    logic [ips_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ips_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // forecast of the sequencer
    ips_pkg::ips_cfg_t timing;
    logic [5:0]        req_bits;
    logic [2:0]        cur_phase;
    logic [20:0]       ph_ticks;
    logic              ph_started;
    logic [2:0]        step_cnt;
    logic              green_shown;
    logic              rest_lamps;
    logic              ticks_on;
    logic [7:0]        lamp_s;
    logic [7:0]        lamp_n;
    logic [7:0]        lamp_x;

    ips_pkg::ips_out_t lamp_words_due[$];
    ips_pkg::ips_out_t want_word;
    int                mismatches = 0;
    int                words_sent = 0;
    logic              idling = 1'b1;
    int                stall_left = 0;
    int                free_left = 0;

    intersection_phase_sequencer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #STOP_NS;
        $display("intersection_phase_sequencer regression: fail");
        $finish;
    end

    // elapsed ticks against half units of the timing unit
    function automatic logic due(input int unsigned half);
        longint unsigned lhs;
        longint unsigned rhs;
        lhs = longint'(ph_ticks) * 2;
        rhs = longint'(half) * longint'(timing.unit_ticks);
        return lhs >= rhs;
    endfunction

    function automatic void close_phase(input int rq, input logic lead_next);
        req_bits[rq] = 1'b0;
        ph_started = 1'b0;
        ph_ticks = '0;
        step_cnt = '0;
        green_shown = 1'b0;
        cur_phase = ips_pkg::PH_NONE;
        if (lead_next && req_bits != 6'd0)
            rest_lamps = 1'b1;
    endfunction

    function automatic void run_lead();
        if (!ph_started)
        begin
            ph_started = 1'b1;
            ph_ticks = '0;
            if (!req_bits[RQ_TRAM] && !req_bits[RQ_BUS] && !req_bits[RQ_MAIN_GO] && lamp_s[5])
                lamp_s = ips_pkg::L_S_LEAD;
            if (!req_bits[RQ_TRAM] && !req_bits[RQ_MAIN_GO] && lamp_n[5])
                lamp_n = ips_pkg::L_N_LEAD;
            rest_lamps = 1'b0;
        end
        if (due(6))
        begin
            rest_lamps = 1'b0;
            ph_started = 1'b0;
            ph_ticks = '0;
        end
    endfunction

    function automatic void serve_phase();
        int unsigned t;
        logic        flashed;
        if (cur_phase == ips_pkg::PH_NONE)
            return;
        if (!ph_started)
        begin
            ph_started = 1'b1;
            ph_ticks = '0;
        end
        case (cur_phase)
            ips_pkg::PH_TRAM:
            begin
                t = timing.tram_time;
                if (due(2 * (t + 4)))
                    close_phase(RQ_TRAM, 1'b1);
                else if (due(2 * (t + 3)) && step_cnt == 3'd0)
                begin
                    step_cnt = 3'd1;
                    lamp_s = ips_pkg::L_S_STOP;
                    lamp_n = ips_pkg::L_N_STOP;
                end
                else if (due(6) && !green_shown)
                begin
                    green_shown = 1'b1;
                    lamp_s = ips_pkg::L_S_TRAM_GO;
                    lamp_n = ips_pkg::L_N_TRAM_GO;
                end
            end
            ips_pkg::PH_BUS:
            begin
                t = timing.bus_time;
                if (due(2 * (t + 4)))
                    close_phase(RQ_BUS, 1'b1);
                else if (due(2 * (t + 3)) && step_cnt == 3'd0)
                begin
                    step_cnt = 3'd1;
                    lamp_n = ips_pkg::L_N_HOLD;
                end
                else if (due(6) && !green_shown)
                begin
                    green_shown = 1'b1;
                    lamp_n = ips_pkg::L_N_BUS_GO;
                    if (req_bits[RQ_TRAM] || req_bits[RQ_MAIN_GO])
                        lamp_s = ips_pkg::L_S_STOP;
                end
            end
            ips_pkg::PH_MAIN_GO:
            begin
                t = timing.main_go_time;
                if (due(2 * (t + 3)))
                    close_phase(RQ_MAIN_GO, 1'b1);
                else if (due(6))
                begin
                    lamp_s = ips_pkg::L_S_STOP;
                    lamp_n = ips_pkg::L_N_STOP;
                end
            end
            ips_pkg::PH_MAIN_TURN:
            begin
                t = timing.main_turn_time;
                if (due(2 * (t + 6)))
                begin
                    close_phase(RQ_MAIN_TURN, 1'b0);
                    lamp_s = ips_pkg::L_S_TURN_STOP;
                end
                else if (due(2 * (t + 3)) && step_cnt == 3'd0)
                begin
                    step_cnt = 3'd1;
                    lamp_s = ips_pkg::L_S_TURN_AMBER;
                end
                else if (due(6) && !green_shown)
                begin
                    green_shown = 1'b1;
                    lamp_s = ips_pkg::L_S_TURN_GO;
                    lamp_n = ips_pkg::L_N_HOLD;
                end
            end
            ips_pkg::PH_SIDE_TURN:
            begin
                t = timing.side_turn_time;
                if (due(2 * (t + 6)))
                begin
                    close_phase(RQ_SIDE_TURN, 1'b0);
                    lamp_x = ips_pkg::L_SIDE_STOP;
                end
                else if (due(2 * (t + 3)) && step_cnt == 3'd0)
                begin
                    step_cnt = 3'd1;
                    lamp_x = ips_pkg::L_SIDE_AMBER;
                end
                else if (due(6) && !green_shown)
                begin
                    green_shown = 1'b1;
                    lamp_s = ips_pkg::L_S_TURN_STOP;
                    lamp_n = ips_pkg::L_N_HOLD;
                    lamp_x = ips_pkg::L_SIDE_GO;
                end
            end
            ips_pkg::PH_PED:
            begin
                t = timing.walk_time;
                flashed = 1'b0;
                if (due(2 * (t + 4)))
                begin
                    lamp_n = ips_pkg::L_N_HOLD;
                    close_phase(RQ_PED, 1'b0);
                    lamp_s = ips_pkg::L_S_STOP;
                end
                else
                begin
                    // flashing in half-unit steps, latest step first
                    for (int k = 5; k >= 0; k--)
                    begin
                        if (!flashed && due(2 * t + k) && step_cnt == 3'(k))
                        begin
                            lamp_n = k[0] ? ips_pkg::L_N_PED_ON : ips_pkg::L_N_PED_OFF;
                            step_cnt = step_cnt + 3'd1;
                            flashed = 1'b1;
                        end
                    end
                    if (!flashed && due(6) && !green_shown)
                    begin
                        green_shown = 1'b1;
                        lamp_s = ips_pkg::L_S_TURN_STOP;
                        lamp_n = ips_pkg::L_N_PED_ON;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void tick_sequencer();
        logic found;
        found = 1'b0;
        if (ph_started && ph_ticks != ips_pkg::ELAPSED_MAX)
            ph_ticks = ph_ticks + 21'd1;
        if (cur_phase == ips_pkg::PH_NONE && req_bits != 6'd0)
        begin
            for (int n = 0; n < ips_pkg::NUM_REQ; n++)
            begin
                if (!found && req_bits[n])
                begin
                    cur_phase = 3'(n + 1);
                    found = 1'b1;
                end
            end
        end
        if (req_bits == 6'd0)
        begin
            if (!rest_lamps)
            begin
                lamp_s = ips_pkg::L_S_STOP;
                lamp_n = ips_pkg::L_N_STOP;
                lamp_x = ips_pkg::L_SIDE_STOP;
                rest_lamps = 1'b1;
            end
            else
                ticks_on = 1'b0;
        end
        else if (rest_lamps)
            run_lead();
        else
            serve_phase();
    endfunction

    function automatic ips_pkg::ips_out_t next_lamp_word(input ips_pkg::ips_in_t w);
        ips_pkg::ips_out_t o;
        logic [7:0]        pressed;
        pressed = ~w.buttons;
        case (w.cmd)
            ips_pkg::CMD_BTN_A:
            begin
                ticks_on = 1'b1;
                if (pressed[0] || pressed[4])
                    req_bits[RQ_MAIN_GO] = 1'b1;
                if (pressed[1])
                    req_bits[RQ_MAIN_TURN] = 1'b1;
                if (pressed[2] || pressed[5])
                    req_bits[RQ_TRAM] = 1'b1;
                if (pressed[3])
                    req_bits[RQ_BUS] = 1'b1;
                if (pressed[6])
                    req_bits[RQ_SIDE_TURN] = 1'b1;
                if (pressed[7])
                    req_bits[RQ_PED] = 1'b1;
            end
            ips_pkg::CMD_BTN_B:
            begin
                ticks_on = 1'b1;
                if (pressed[0] || pressed[1])
                    req_bits[RQ_PED] = 1'b1;
            end
            ips_pkg::CMD_TICK:
            begin
                if (ticks_on)
                    tick_sequencer();
            end
            default:
            begin
            end
        endcase
        o.lamps_south = lamp_s;
        o.lamps_north = lamp_n;
        o.lamps_side  = lamp_x;
        o.pending     = req_bits;
        o.serving     = cur_phase;
        o.ticking     = ticks_on;
        return o;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t ns: %s got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (lamp_words_due.size() == 0)
                flag_mismatch("word with none due", 32'(result_data), 32'd0);
            else
            begin
                want_word = lamp_words_due.pop_front();
                if (result_data.lamps_south !== want_word.lamps_south)
                    flag_mismatch("lamps_south", 32'(result_data.lamps_south),
                                  32'(want_word.lamps_south));
                if (result_data.lamps_north !== want_word.lamps_north)
                    flag_mismatch("lamps_north", 32'(result_data.lamps_north),
                                  32'(want_word.lamps_north));
                if (result_data.lamps_side !== want_word.lamps_side)
                    flag_mismatch("lamps_side", 32'(result_data.lamps_side),
                                  32'(want_word.lamps_side));
                if (result_data.pending !== want_word.pending)
                    flag_mismatch("pending", 32'(result_data.pending),
                                  32'(want_word.pending));
                if (result_data.serving !== want_word.serving)
                    flag_mismatch("serving", 32'(result_data.serving),
                                  32'(want_word.serving));
                if (result_data.ticking !== want_word.ticking)
                    flag_mismatch("ticking", 32'(result_data.ticking),
                                  32'(want_word.ticking));
            end
        end
    end

    // receiver stalls in bursts
    always @(negedge clk)
    begin
        if (!idling)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
            free_left = 0;
        end
        else if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else if (free_left != 0)
        begin
            result_stall <= 1'b0;
            free_left--;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            result_stall <= 1'b1;
            stall_left = $urandom_range(1, 13) - 1;
        end
        else
        begin
            result_stall <= 1'b0;
            free_left = $urandom_range(0, 24);
        end
    end

    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
    endtask

    task automatic send_word(input logic [1:0] cmd, input logic [7:0] btn);
        ips_pkg::ips_in_t w;
        w.cmd = cmd;
        w.buttons = btn;
        if (idling && $urandom_range(0, 4) == 0)
            hold_off($urandom_range(1, 13));
        @(negedge clk);
        item_valid <= 1'b1;
        item_data <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        lamp_words_due.push_back(next_lamp_word(w));
        if (cmd != CMD_UNUSED)
            words_sent++;
    endtask

    // hold the sender until every due word is back
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (lamp_words_due.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic poke_reg(input logic [ips_pkg::CFG_IDX_W-1:0] idx,
                            input logic [ips_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    task automatic load_timing(input ips_pkg::ips_cfg_t c);
        poke_reg(ips_pkg::CFG_UNIT_TICKS, c.unit_ticks);
        poke_reg(ips_pkg::CFG_TRAM_TIME, 12'(c.tram_time));
        poke_reg(ips_pkg::CFG_BUS_TIME, 12'(c.bus_time));
        poke_reg(ips_pkg::CFG_MAIN_GO_TIME, 12'(c.main_go_time));
        poke_reg(ips_pkg::CFG_MAIN_TURN_TIME, 12'(c.main_turn_time));
        poke_reg(ips_pkg::CFG_SIDE_TURN_TIME, 12'(c.side_turn_time));
        poke_reg(ips_pkg::CFG_WALK_TIME, 12'(c.walk_time));
        @(negedge clk);
        cfg_we <= 1'b0;
        timing = c;
    endtask

    function automatic ips_pkg::ips_cfg_t pick_timing();
        ips_pkg::ips_cfg_t c;
        int                r;
        r = $urandom_range(0, 9);
        c.unit_ticks     = (r < 7) ? 12'd1 : 12'($urandom_range(2, 3));
        c.tram_time      = 8'($urandom_range(0, 5));
        c.bus_time       = 8'($urandom_range(0, 5));
        c.main_go_time   = 8'($urandom_range(0, 5));
        c.main_turn_time = 8'($urandom_range(0, 5));
        c.side_turn_time = 8'($urandom_range(0, 5));
        c.walk_time      = 8'($urandom_range(0, 5));
        return c;
    endfunction

    task automatic press_random();
        logic [7:0] btn;
        case ($urandom_range(0, 5))
            0, 1, 2: btn = ~(8'd1 << $urandom_range(0, 7));
            3:       btn = ~((8'd1 << $urandom_range(0, 7)) | (8'd1 << $urandom_range(0, 7)));
            4:       btn = 8'($urandom);
            default: btn = 8'hFF;
        endcase
        if ($urandom_range(0, 4) == 0)
            send_word(ips_pkg::CMD_BTN_B, btn);
        else
            send_word(ips_pkg::CMD_BTN_A, btn);
    endtask

    // buttons, then ticks until the sequencer stops or tick_cap is reached, with some noise
    task automatic run_traffic(input int tick_cap);
        int n;
        int r;
        n = 0;
        repeat ($urandom_range(1, 3)) press_random();
        while (ticks_on && n < tick_cap)
        begin
            r = $urandom_range(0, 39);
            if (r == 0 || r == 1)
                send_word(CMD_UNUSED, 8'($urandom));
            else if (r == 2 || r == 3)
                press_random();
            else if (r == 4)
                settle();
            else
                send_word(ips_pkg::CMD_TICK, 8'($urandom));
            n++;
        end
        send_word(ips_pkg::CMD_TICK, 8'($urandom));
    endtask

    task automatic test_idle_stop();
        send_word(CMD_UNUSED, 8'h00);
        send_word(ips_pkg::CMD_TICK, 8'hFF);
        send_word(ips_pkg::CMD_TICK, 8'h00);
        send_word(ips_pkg::CMD_TICK, 8'h5A);
        send_word(ips_pkg::CMD_BTN_A, 8'hFF);
        send_word(ips_pkg::CMD_TICK, 8'hA5);
        send_word(ips_pkg::CMD_BTN_B, 8'hFF);
        send_word(ips_pkg::CMD_TICK, 8'h00);
    endtask

    task automatic test_button_map();
        send_word(ips_pkg::CMD_BTN_B, 8'h03);
        for (int k = 0; k < 8; k++)
            send_word(ips_pkg::CMD_BTN_A, ~(8'd1 << k));
        send_word(ips_pkg::CMD_BTN_B, 8'hFE);
        send_word(ips_pkg::CMD_BTN_B, 8'hFD);
        send_word(ips_pkg::CMD_BTN_A, 8'h00);
    endtask

    // zero lengths: every green time is zero and unit_ticks is one
    task automatic test_zero_times();
        ips_pkg::ips_cfg_t c;
        int                n;
        c = '{unit_ticks: 12'd1, default: 8'd0};
        n = 0;
        settle();
        load_timing(c);
        while (ticks_on && n < 200)
        begin
            send_word(ips_pkg::CMD_TICK, 8'($urandom));
            n++;
        end
        run_traffic(200);
    endtask

    task automatic test_long_timing();
        ips_pkg::ips_cfg_t c;
        c = '{unit_ticks: 12'd4095, default: 8'd255};
        settle();
        load_timing(c);
        send_word(ips_pkg::CMD_BTN_A, 8'h00);
        send_word(ips_pkg::CMD_BTN_B, 8'hFC);
        repeat (30) send_word(ips_pkg::CMD_TICK, 8'($urandom));
    endtask

    task automatic test_random_traffic();
        while (words_sent < 440)
        begin
            settle();
            load_timing(pick_timing());
            idling = ($urandom_range(0, 3) != 0);
            run_traffic(150);
        end
    endtask

    task automatic test_quiet_tail();
        idling = 1'b0;
        settle();
        load_timing(pick_timing());
        send_word(ips_pkg::CMD_BTN_A, 8'h00);
        run_traffic(80);
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        timing = '{unit_ticks: 12'd300, tram_time: 8'd10, bus_time: 8'd4,
                   main_go_time: 8'd10, main_turn_time: 8'd5, side_turn_time: 8'd5,
                   walk_time: 8'd10};
        req_bits = '0;
        cur_phase = ips_pkg::PH_NONE;
        ph_ticks = '0;
        ph_started = 1'b0;
        step_cnt = '0;
        green_shown = 1'b0;
        rest_lamps = 1'b0;
        ticks_on = 1'b1;
        lamp_s = '0;
        lamp_n = '0;
        lamp_x = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_stop();
        test_button_map();
        test_zero_times();
        test_long_timing();
        test_random_traffic();
        test_quiet_tail();

        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("intersection_phase_sequencer regression: pass");
        else
            $display("intersection_phase_sequencer regression: fail");
        $finish;
    end

endmodule
